/* sv/kesd_pkg.sv */
// Shared types and constants for the key escape sequence decoder.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package kesd_pkg;

    localparam int MAX_SEQ_LEN = 4;     // bytes held in the pending buffer
    localparam int NUM_SEQS    = 4;     // configured key sequences
    localparam int MAX_RESULTS = 4;     // results one input byte may cause
    localparam int BYTE_W      = 8;
    localparam int CODE_W      = 16;
    localparam int LEN_W       = 3;     // length field per sequence
    localparam int CNT_W       = 3;     // holds 0 .. MAX_SEQ_LEN
    localparam int IDX_W       = 2;     // addresses one pending byte
    localparam int NRES_W      = 3;     // holds 0 .. MAX_RESULTS
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int SEQ_W       = 32;
    localparam int LENS_W      = 12;
    localparam int VCODES_W    = 64;
    localparam int DMAP_W      = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    localparam logic [LENS_W-1:0] LENS_RESET = LENS_W'(1755);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEQ0     = 3'd0,
        REG_SEQ1     = 3'd1,
        REG_SEQ2     = 3'd2,
        REG_SEQ3     = 3'd3,
        REG_SEQ_LENS = 3'd4,
        REG_VCODES   = 3'd5,
        REG_DEL_MAP  = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEC_EMPTY,      // nothing pending
        DEC_WAIT,       // partial agreement, need more bytes
        DEC_VIRT,       // full sequence matched
        DEC_CHAR        // no agreement, front byte goes out plain
    } t_decision;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic append;       // store the accepted byte
        logic capture;      // load decided result into hold, drop its bytes
        logic push;         // move hold into the output register
        logic push_last;    // pushed result ends this byte's run
    } t_cmd;

    typedef struct packed {
        t_decision decision;
        logic      out_free;
    } t_status;

endpackage

/* sv/kesd_ctrl.sv */
// Sequencer for the key escape sequence decoder: steps the match/emit loop.
// Depends on kesd_pkg; drives commands into kesd_dp.
`timescale 1ns / 1ps

module kesd_ctrl
    import kesd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state             r_state, n_state;
    logic               r_hold_valid, n_hold_valid;
    logic [NRES_W-1:0]  r_nres, n_nres;
    logic               w_more;
    logic               w_stall;
    logic               w_accept;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_more   = ((i_sts.decision == DEC_VIRT) || (i_sts.decision == DEC_CHAR))
                      && (r_nres < NRES_W'(MAX_RESULTS));
    // a held result can only leave once the output register has room
    assign w_stall  = r_hold_valid && !i_sts.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!w_stall && !w_more) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.append = i_in_valid;
            end
            ST_EVAL: begin
                if (!w_stall) begin
                    o_cmd.capture   = w_more;
                    o_cmd.push      = r_hold_valid;
                    o_cmd.push_last = !w_more;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_hold_valid = r_hold_valid;
        n_nres       = r_nres;
        if (w_accept) begin
            n_nres = '0;
        end
        if (o_cmd.capture) begin
            n_hold_valid = 1'b1;
            n_nres       = r_nres + NRES_W'(1);
        end else if (o_cmd.push) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_hold_valid <= 1'b0;
            r_nres       <= '0;
        end else begin
            r_state      <= n_state;
            r_hold_valid <= n_hold_valid;
            r_nres       <= n_nres;
        end
    end

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("result count beyond limit");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_valid)
        else $error("held result left behind in idle");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> i_sts.out_free)
        else $error("push into a full output register");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EVAL))
        else $error("accepted byte not evaluated");

endmodule

/* sv/kesd_dp.sv */
// Datapath of the key escape sequence decoder: configuration, pending
// buffer, sequence matcher, hold and output registers. Depends on kesd_pkg.
`timescale 1ns / 1ps

module kesd_dp
    import kesd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [BYTE_W-1:0]      i_in_byte,
    input  t_cmd                   i_cmd,
    output t_status                o_sts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [CODE_W-1:0]      o_key_code,
    output logic                   o_is_virtual,
    output logic                   o_last
);

    localparam int BUF_W = MAX_SEQ_LEN * BYTE_W;

    logic [SEQ_W-1:0]     r_seq_bytes [NUM_SEQS];
    logic [LENS_W-1:0]    r_seq_lens;
    logic [VCODES_W-1:0]  r_vcodes;
    logic [DMAP_W-1:0]    r_del_map;

    logic [BUF_W-1:0]     r_buf, n_buf;
    logic [CNT_W-1:0]     r_count, n_count;

    logic [CODE_W-1:0]    r_hold_code;
    logic                 r_hold_virt;
    logic                 r_out_valid;
    logic [CODE_W-1:0]    r_out_code;
    logic                 r_out_virt;
    logic                 r_out_last;

    t_decision            w_dec;
    logic [CODE_W-1:0]    w_code;
    logic [CNT_W-1:0]     w_drop;
    logic [BYTE_W-1:0]    w_char;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SEQS; s++) r_seq_bytes[s] <= '0;
            r_seq_lens <= LENS_RESET;
            r_vcodes   <= '0;
            r_del_map  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SEQ0:     r_seq_bytes[0] <= i_cfg_data[SEQ_W-1:0];
                REG_SEQ1:     r_seq_bytes[1] <= i_cfg_data[SEQ_W-1:0];
                REG_SEQ2:     r_seq_bytes[2] <= i_cfg_data[SEQ_W-1:0];
                REG_SEQ3:     r_seq_bytes[3] <= i_cfg_data[SEQ_W-1:0];
                REG_SEQ_LENS: r_seq_lens     <= i_cfg_data[LENS_W-1:0];
                REG_VCODES:   r_vcodes       <= i_cfg_data[VCODES_W-1:0];
                REG_DEL_MAP:  r_del_map      <= i_cfg_data[DMAP_W-1:0];
                default: ;
            endcase
        end
    end

    // matcher: first agreeing sequence in index order decides
    always_comb begin
        logic [LEN_W-1:0] fld;
        logic [CNT_W-1:0] len;
        logic             agree;
        w_char = r_buf[BYTE_W-1:0];
        if (w_char == r_del_map[BYTE_W-1:0]) w_char = r_del_map[DMAP_W-1:BYTE_W];
        w_dec  = DEC_CHAR;
        w_code = CODE_W'(w_char);
        w_drop = CNT_W'(1);
        for (int s = NUM_SEQS - 1; s >= 0; s--) begin
            fld   = r_seq_lens[s*LEN_W +: LEN_W];
            len   = (fld > LEN_W'(MAX_SEQ_LEN)) ? CNT_W'(MAX_SEQ_LEN) : fld;
            agree = (fld != '0);
            for (int k = 0; k < MAX_SEQ_LEN; k++) begin
                if ((CNT_W'(k) < r_count) && (CNT_W'(k) < len)
                    && (r_buf[k*BYTE_W +: BYTE_W] != r_seq_bytes[s][k*BYTE_W +: BYTE_W]))
                    agree = 1'b0;
            end
            if (agree) begin
                w_dec  = (r_count >= len) ? DEC_VIRT : DEC_WAIT;
                w_code = r_vcodes[s*CODE_W +: CODE_W];
                w_drop = len;
            end
        end
        if (r_count == '0) w_dec = DEC_EMPTY;
    end

    assign o_sts.decision = w_dec;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // pending buffer: append on accept, shift out consumed bytes on capture
    always_comb begin
        n_buf   = r_buf;
        n_count = r_count;
        if (i_cmd.append && (r_count < CNT_W'(MAX_SEQ_LEN))) begin
            n_buf[r_count[IDX_W-1:0]*BYTE_W +: BYTE_W] = i_in_byte;
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.capture) begin
            n_buf   = r_buf >> {w_drop, 3'b000};
            n_count = r_count - w_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_count <= '0;
        end else begin
            r_buf   <= n_buf;
            r_count <= n_count;
        end
    end

    // hold the newest result until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_hold_code <= w_code;
            r_hold_virt <= (w_dec == DEC_VIRT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_code <= r_hold_code;
            r_out_virt <= r_hold_virt;
            r_out_last <= i_cmd.push_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_key_code   = r_out_code;
    assign o_is_virtual = r_out_virt;
    assign o_last       = r_out_last;

endmodule

/* sv/key_escape_sequence_decoder_top.sv */
// Key escape sequence decoder, top level: joins sequencer and datapath.
// Depends on kesd_pkg, kesd_ctrl and kesd_dp.
//
// Usage:
//   Slave stream s_axis_* carries one raw terminal byte per request.
//   Master stream m_axis_* carries results: a plain character or the
//   virtual code of a matched key sequence in tdata, tuser high for a
//   virtual code; tlast marks the final result caused by one input byte.
//   A byte that leaves a partial match causes no result and stays pending.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (0..3 sequence bytes, 4 lengths, 5 virtual codes, 6 delete map);
//   write only while the block is idle.
// Timing:
//   An accepted byte is first stored in the pending buffer; then each
//   result is captured into the hold register while the previous one is
//   pushed to the output register, and a final step pushes the last one.
//   The combinational matcher over the pending buffer sets the pace, and
//   each result reaches m_axis through the hold and output registers.
//   When the receiver stalls, the output register holds its request and
//   the sequencer waits with the next result; a new byte is taken as soon
//   as the previous one has been fully matched.
// Reset: synchronous, active low; clears the pending buffer and loads the
//   register defaults (all lengths three, everything else zero).
`timescale 1ns / 1ps

module key_escape_sequence_decoder_top
    import kesd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // [7:0] in_byte
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // [15:0] key_code
    output logic                    m_axis_tuser,   // [0] is_virtual
    output logic                    m_axis_tlast    // last
);

    t_cmd              w_cmd;
    t_status           w_sts;

    kesd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kesd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_byte    (s_axis_tdata[BYTE_W-1:0]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_key_code   (m_axis_tdata),
        .o_is_virtual (m_axis_tuser),
        .o_last       (m_axis_tlast)
    );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for key_escape_sequence_decoder_top: directed key
// sequences, length and delete-map corner cases, then random traffic over
// several register settings. Depends on kesd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module testbench;
    import kesd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 11;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PHASES        = 9;
    localparam int PHASE_BYTES   = 45;
    localparam int REPORT_LIMIT  = 10;
    localparam longint TIMEOUT_NS = 2_000_000;

    // index beyond the register map, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [7:0] ESC = 8'h1B;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              virt;
        logic              last;
    } t_key_result;

    typedef struct {
        logic [SEQ_W-1:0]    words[NUM_SEQS];
        logic [LENS_W-1:0]   lens;
        logic [VCODES_W-1:0] codes;
        logic [DMAP_W-1:0]   dmap;
    } t_key_setup;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   m_axis_tlast;

    // decoder state and register copies used for prediction
    logic [SEQ_W-1:0]    seq_word[NUM_SEQS] = '{default: '0};
    logic [LENS_W-1:0]   seq_lens = LENS_RESET;
    logic [VCODES_W-1:0] vcodes   = '0;
    logic [DMAP_W-1:0]   del_map  = '0;
    logic [BYTE_W-1:0]   pend_bytes[MAX_SEQ_LEN] = '{default: '0};
    int                  pend_count = 0;

    t_key_result expected_keys[$];
    t_key_result want_key;
    t_key_result got_key;

    bit steady = 1'b0;
    int failures = 0;
    int bytes_sent = 0;
    int keys_seen = 0;
    int virt_seen = 0;
    int settings_applied = 0;

    key_escape_sequence_decoder_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic void drop_pending(input int n);
        int k;
        if (n > pend_count) n = pend_count;
        for (k = 0; k + n < pend_count; k++) pend_bytes[k] = pend_bytes[k + n];
        pend_count -= n;
    endfunction

    // Append one byte and resolve the pending buffer into decoded keys.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        t_key_result found[$];
        int s, k, len, n;
        bit decided, waiting, agree;
        logic [BYTE_W-1:0] c;
        if (pend_count < MAX_SEQ_LEN) begin
            pend_bytes[pend_count] = b;
            pend_count++;
        end
        while (pend_count > 0 && found.size() < MAX_RESULTS) begin
            decided = 1'b0;
            waiting = 1'b0;
            for (s = 0; s < NUM_SEQS && !decided; s++) begin
                len = seq_lens[LEN_W*s +: LEN_W];
                if (len > MAX_SEQ_LEN) len = MAX_SEQ_LEN;
                n = (pend_count < len) ? pend_count : len;
                agree = (len != 0);
                for (k = 0; k < n; k++)
                    if (pend_bytes[k] != seq_word[s][BYTE_W*k +: BYTE_W]) agree = 1'b0;
                if (agree) begin
                    decided = 1'b1;
                    if (n == len) begin
                        found.push_back('{code: vcodes[CODE_W*s +: CODE_W], virt: 1'b1,
                                          last: 1'b0});
                        drop_pending(len);
                    end else begin
                        waiting = 1'b1;
                    end
                end
            end
            if (waiting) break;
            if (!decided) begin
                c = pend_bytes[0];
                if (c == del_map[7:0]) c = del_map[15:8];
                found.push_back('{code: {8'h00, c}, virt: 1'b0, last: 1'b0});
                drop_pending(1);
            end
        end
        if (found.size() > 0) found[found.size() - 1].last = 1'b1;
        foreach (found[i]) expected_keys.push_back(found[i]);
    endfunction

    function automatic void note_failure(input string what, input t_key_result want,
                                         input t_key_result got);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%t %s: expected code %h virt %b last %b, got code %h virt %b last %b",
                     $realtime, what, want.code, want.virt, want.last,
                     got.code, got.virt, got.last);
    endfunction

    // Receiver: random back-pressure unless steady, check every accepted key in order.
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_key = '{code: m_axis_tdata, virt: m_axis_tuser, last: m_axis_tlast};
            keys_seen++;
            if (got_key.virt) virt_seen++;
            if (expected_keys.size() == 0) begin
                note_failure("unexpected key", '0, got_key);
            end else begin
                want_key = expected_keys.pop_front();
                if (want_key.code != got_key.code || want_key.virt != got_key.virt ||
                    want_key.last != got_key.last)
                    note_failure("key mismatch", want_key, got_key);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (!steady) while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Drop the request, wait for every outstanding key, then let the block settle.
    task automatic pause_and_drain();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (expected_keys.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_keys.size() != 0) begin
            failures += expected_keys.size();
            $display("%t %0d expected keys never arrived", $realtime, expected_keys.size());
            expected_keys.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            REG_SEQ0, REG_SEQ1, REG_SEQ2, REG_SEQ3: seq_word[idx[1:0]] = data[SEQ_W-1:0];
            REG_SEQ_LENS: seq_lens = data[LENS_W-1:0];
            REG_VCODES:   vcodes   = data[VCODES_W-1:0];
            REG_DEL_MAP:  del_map  = data[DMAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_key_setup st);
        int s;
        for (s = 0; s < NUM_SEQS; s++)
            write_reg(t_reg_idx'(int'(REG_SEQ0) + s), CFG_DATA_W'(st.words[s]));
        write_reg(REG_SEQ_LENS, CFG_DATA_W'(st.lens));
        write_reg(REG_VCODES, CFG_DATA_W'(st.codes));
        write_reg(REG_DEL_MAP, CFG_DATA_W'(st.dmap));
        end_writes();
        settings_applied++;
    endtask

    // Escape-like sequences: most share a lead byte, some share a second byte.
    function automatic t_key_setup random_setup();
        t_key_setup st;
        logic [7:0] lead;
        int s;
        lead = 8'($urandom_range(255));
        st.lens = '0;
        for (s = 0; s < NUM_SEQS; s++) begin
            st.words[s] = $urandom;
            if ($urandom_range(3) != 0) st.words[s][7:0] = lead;
            if (s > 0 && $urandom_range(1) != 0) st.words[s][15:8] = st.words[0][15:8];
            st.lens[LEN_W*s +: LEN_W] = 3'($urandom_range(7));
        end
        st.codes = {$urandom, $urandom};
        st.dmap  = {8'($urandom_range(255)),
                    ($urandom_range(1) != 0) ? lead : 8'($urandom_range(255))};
        return st;
    endfunction

    // Mostly whole or cut-short key sequences, occasionally corrupted; else noise.
    task automatic send_burst(output int n);
        int s, len, cut, k, r;
        logic [7:0] b;
        n = 0;
        r = $urandom_range(99);
        if (r < 70) begin
            s = $urandom_range(NUM_SEQS - 1);
            len = seq_lens[LEN_W*s +: LEN_W];
            if (len > MAX_SEQ_LEN || len == 0) len = MAX_SEQ_LEN;
            cut = ($urandom_range(3) != 0) ? len : $urandom_range(len, 1);
            for (k = 0; k < cut; k++) begin
                b = seq_word[s][BYTE_W*k +: BYTE_W];
                if ($urandom_range(19) == 0) b = 8'($urandom_range(255));
                send_byte(b);
                n++;
            end
        end else begin
            if (r < 85)      b = 8'($urandom_range(255));
            else if (r < 93) b = del_map[7:0];
            else             b = seq_word[0][7:0];
            send_byte(b);
            n = 1;
        end
    endtask

    // Power-up registers: every sequence is three zero bytes.
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    // Cursor keys, a lone escape key and a sequence that falls apart part way.
    task automatic test_escape_keys();
        t_key_setup st;
        st.words = '{32'h00415B1B, 32'h00425B1B, {24'h0, ESC}, 32'h7E315B1B};
        st.lens  = {3'd4, 3'd1, 3'd3, 3'd3};
        st.codes = {16'h0104, 16'h0103, 16'h0102, 16'h0101};
        st.dmap  = '0;
        pause_and_drain();
        apply_setup(st);
        send_byte(ESC); send_byte(8'h5B); send_byte(8'h41);
        send_byte(ESC); send_byte(8'h78);
        send_byte(ESC); send_byte(8'h5B); send_byte(8'h5A);
    endtask

    // Disabled and saturated lengths; junk above the lengths field must be dropped.
    task automatic test_length_limits();
        pause_and_drain();
        write_reg(REG_SEQ0, 64'h0000_0000_0000_0041);
        write_reg(REG_SEQ1, 64'h0000_0000_4443_4241);
        write_reg(REG_SEQ_LENS, {52'hF_FFFF_FFFF_FFFF, 3'd0, 3'd0, 3'd7, 3'd0});
        end_writes();
        send_byte(8'h41); send_byte(8'h42); send_byte(8'h43); send_byte(8'h44);
        // three bytes held, then a mismatch flushes four plain keys at once
        send_byte(8'h41); send_byte(8'h42); send_byte(8'h43); send_byte(8'h58);
    endtask

    task automatic test_delete_replacement();
        pause_and_drain();
        write_reg(REG_DEL_MAP, 64'h087F);
        end_writes();
        send_byte(8'h7F);
        send_byte(8'h08);
        pause_and_drain();
        write_reg(REG_SPARE, '1);
        end_writes();
        send_byte(8'h7F);
    endtask

    task automatic test_random_traffic();
        t_key_setup st;
        int phase, sent, n;
        bit paused;
        for (phase = 0; phase < PHASES; phase++) begin
            st = random_setup();
            case (phase)
                0: begin
                    st.words = '{default: '1};
                    st.lens  = {3'd4, 3'd4, 3'd4, 3'd4};
                    st.codes = '1;
                    st.dmap  = '1;
                end
                1: st.lens = '0;
                2: begin
                    st.words = '{default: '0};
                    st.lens  = '1;
                    st.codes = '0;
                    st.dmap  = '0;
                end
                default: ;
            endcase
            pause_and_drain();
            apply_setup(st);
            steady = (phase == 5);
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_BYTES) begin
                send_burst(n);
                sent += n;
                if (phase == 6 && sent >= PHASE_BYTES / 2 && !paused) begin
                    pause_and_drain();
                    paused = 1'b1;
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_escape_keys();
        test_length_limits();
        test_delete_replacement();
        test_random_traffic();
        pause_and_drain();

        $display("Sent %0d terminal bytes under %0d register settings;", bytes_sent,
                 settings_applied);
        $display("checked %0d decoded keys, %0d of them from key sequences.", keys_seen,
                 virt_seen);
        if (failures == 0) begin
            $display("PASS key_escape_sequence_decoder_top");
        end else begin
            $display("FAIL key_escape_sequence_decoder_top");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out");
        $display("FAIL key_escape_sequence_decoder_top");
        $finish;
    end

endmodule
